### rtl/fpcc_pkg.sv
// Package: shared types, constants and lookup functions of the front-panel clock controller.
`default_nettype none
package fpcc_pkg;

    localparam int EFFECT_COUNT = 15;
    localparam logic [3:0] EFFECT_LAST = 4'(EFFECT_COUNT - 1);

    localparam logic [1:0] CFG_HOLD_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_BLINK_DIVIDE   = 2'd1;
    localparam logic [1:0] CFG_RAMP_TOP       = 2'd2;

    localparam logic [11:0] HOLD_THRESHOLD_RST = 12'd200;
    localparam logic [7:0]  BLINK_DIVIDE_RST   = 8'h20;
    localparam logic [9:0]  RAMP_TOP_RST       = 10'h3ff;

    localparam logic [1:0] ADJ_NONE    = 2'd0;
    localparam logic [1:0] ADJ_HOURS   = 2'd1;
    localparam logic [1:0] ADJ_MINUTES = 2'd2;

    localparam logic [1:0] GROUP_ONE = 2'b01;
    localparam logic [1:0] GROUP_TWO = 2'b10;

    typedef enum logic [2:0] {
        OP_SECOND  = 3'd0,
        OP_FAST    = 3'd1,
        OP_POWER   = 3'd2,
        OP_CHAN1   = 3'd3,
        OP_CHAN2   = 3'd4,
        OP_NEXT    = 3'd5,
        OP_PREV    = 3'd6,
        OP_LOWVOLT = 3'd7
    } t_opcode;

    typedef struct packed {
        logic        valid;
        t_opcode     opcode;
        logic [11:0] hold_ticks;
    } t_event;

    typedef struct packed {
        logic [5:0] selector_lines;
        logic [3:0] effect_code;
        logic [3:0] effect_index;
        logic       amp_on;
        logic [9:0] ramp_duty;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [1:0] adjust_mode;
        logic       powered;
        logic       asleep;
    } t_result;

    function automatic logic [5:0] key_one(input logic [1:0] pos);
        logic [5:0] k;
        case (pos)
            2'd0:    k = 6'd1;
            2'd1:    k = 6'd2;
            2'd2:    k = 6'd4;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] key_two(input logic [1:0] pos);
        logic [5:0] k;
        case (pos)
            2'd0:    k = 6'd8;
            2'd1:    k = 6'd16;
            2'd2:    k = 6'd32;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] effect_code(input logic [3:0] sel);
        logic [3:0] c;
        case (sel)
            4'd0:    c = 4'd9;
            4'd1:    c = 4'd13;
            4'd2:    c = 4'd5;
            4'd3:    c = 4'd1;
            4'd4:    c = 4'd0;
            4'd5:    c = 4'd4;
            4'd6:    c = 4'd6;
            4'd7:    c = 4'd2;
            4'd8:    c = 4'd15;
            4'd9:    c = 4'd11;
            4'd10:   c = 4'd3;
            4'd11:   c = 4'd10;
            4'd12:   c = 4'd14;
            4'd13:   c = 4'd7;
            4'd14:   c = 4'd8;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/fpcc_if.sv
// Interfaces: event request channel and result channel.
`default_nettype none
interface fpcc_in_if;
    logic                 valid;
    logic                 ready;
    fpcc_pkg::t_opcode    opcode;
    logic [11:0]          hold_ticks;

    modport source (output valid, output opcode, output hold_ticks, input ready);
    modport sink   (input valid, input opcode, input hold_ticks, output ready);
endinterface

interface fpcc_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] selector_lines;
    logic [3:0] effect_code;
    logic [3:0] effect_index;
    logic       amp_on;
    logic [9:0] ramp_duty;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [1:0] adjust_mode;
    logic       powered;
    logic       asleep;

    modport source (output valid, output selector_lines, output effect_code,
                    output effect_index, output amp_on, output ramp_duty, output hours,
                    output minutes, output seconds, output adjust_mode, output powered,
                    output asleep, input ready);
    modport sink   (input valid, input selector_lines, input effect_code,
                    input effect_index, input amp_on, input ramp_duty, input hours,
                    input minutes, input seconds, input adjust_mode, input powered,
                    input asleep, output ready);
endinterface
`default_nettype wire

### rtl/fpcc_in_stage.sv
// Input register: captures one event request and holds it until the core takes it.
`default_nettype none
module fpcc_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire fpcc_pkg::t_opcode i_opcode,
    input  wire logic [11:0]       i_hold_ticks,
    output logic                   o_ready,
    input  wire logic              i_advance,
    output fpcc_pkg::t_event       o_event
);
    logic              r_valid;
    fpcc_pkg::t_opcode r_opcode;
    logic [11:0]       r_hold;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_opcode <= i_opcode;
            r_hold   <= i_hold_ticks;
        end
    end

    assign o_event = '{valid: r_valid, opcode: r_opcode, hold_ticks: r_hold};
endmodule
`default_nettype wire

### rtl/fpcc_core.sv
// Event core: panel state, clock, ramp, configuration registers and next-state logic.
`default_nettype none
module fpcc_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [11:0]      i_cfg_data,
    input  wire fpcc_pkg::t_event i_event,
    input  wire logic             i_fire,
    output fpcc_pkg::t_result     o_result
);
    logic [11:0] r_hold_thr;
    logic [7:0]  r_blink_div;
    logic [9:0]  r_ramp_top;

    logic       r_power, n_power;
    logic       r_sleep, n_sleep;
    logic [5:0] r_line, n_line;
    logic [1:0] r_pos1, n_pos1;
    logic [1:0] r_pos2, n_pos2;
    logic [1:0] r_blink, n_blink;
    logic [3:0] r_effect, n_effect;
    logic [1:0] r_adjust, n_adjust;
    logic [4:0] r_hour, n_hour;
    logic [5:0] r_minute, n_minute;
    logic [5:0] r_second, n_second;
    logic [7:0] r_prescale, n_prescale;
    logic [9:0] r_duty, n_duty;
    logic       r_ramp_up, n_ramp_up;
    logic       r_ramp_down, n_ramp_down;
    logic       r_amp, n_amp;

    logic       awake;
    logic       long_press;
    logic [1:0] ch_bit;
    logic [1:0] ch_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_thr  <= fpcc_pkg::HOLD_THRESHOLD_RST;
            r_blink_div <= fpcc_pkg::BLINK_DIVIDE_RST;
            r_ramp_top  <= fpcc_pkg::RAMP_TOP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fpcc_pkg::CFG_HOLD_THRESHOLD: r_hold_thr  <= i_cfg_data;
                fpcc_pkg::CFG_BLINK_DIVIDE:   r_blink_div <= i_cfg_data[7:0];
                fpcc_pkg::CFG_RAMP_TOP:       r_ramp_top  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_power     = r_power;
        n_sleep     = r_sleep;
        n_line      = r_line;
        n_pos1      = r_pos1;
        n_pos2      = r_pos2;
        n_blink     = r_blink;
        n_effect    = r_effect;
        n_adjust    = r_adjust;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_second    = r_second;
        n_prescale  = r_prescale;
        n_duty      = r_duty;
        n_ramp_up   = r_ramp_up;
        n_ramp_down = r_ramp_down;
        n_amp       = r_amp;

        awake      = !r_sleep;
        long_press = i_event.hold_ticks > r_hold_thr;
        ch_bit     = (i_event.opcode == fpcc_pkg::OP_CHAN1) ? fpcc_pkg::GROUP_ONE
                                                            : fpcc_pkg::GROUP_TWO;
        ch_pos     = (i_event.opcode == fpcc_pkg::OP_CHAN1) ? r_pos1 : r_pos2;

        case (i_event.opcode)
            fpcc_pkg::OP_SECOND: begin
                if (r_second >= 6'd59) begin
                    n_second = 6'd0;
                    if (r_minute >= 6'd59) begin
                        n_minute = 6'd0;
                        n_hour   = (r_hour >= 5'd23) ? 5'd0 : r_hour + 5'd1;
                    end else begin
                        n_minute = r_minute + 6'd1;
                    end
                end else begin
                    n_second = r_second + 6'd1;
                end
                n_sleep = 1'b0;
            end
            fpcc_pkg::OP_FAST: if (awake) begin
                n_prescale = r_prescale + 8'd1;
                if (n_prescale == r_blink_div) begin
                    if (r_blink[0]) n_line = n_line ^ fpcc_pkg::key_one(r_pos1);
                    if (r_blink[1]) n_line = n_line ^ fpcc_pkg::key_two(r_pos2);
                    n_prescale = 8'd0;
                end
                if (r_ramp_up) begin
                    if (r_duty < r_ramp_top) n_duty = r_duty + 10'd1;
                    if (n_duty >= r_ramp_top) n_ramp_up = 1'b0;
                end
                if (r_ramp_down) begin
                    if (n_duty != 10'd0) n_duty = n_duty - 10'd1;
                    if (n_duty == 10'd0) n_ramp_down = 1'b0;
                end
            end
            fpcc_pkg::OP_POWER: if (awake) begin
                if (!r_power) begin
                    n_amp       = 1'b1;
                    n_power     = 1'b1;
                    n_effect    = 4'd0;
                    n_line      = fpcc_pkg::key_one(r_pos1) + fpcc_pkg::key_two(r_pos2);
                    n_ramp_down = 1'b0;
                    n_ramp_up   = 1'b1;
                end else begin
                    n_amp       = 1'b0;
                    n_power     = 1'b0;
                    n_line      = 6'd0;
                    n_blink     = 2'b00;
                    n_pos1      = 2'd0;
                    n_pos2      = 2'd0;
                    n_ramp_up   = 1'b0;
                    n_ramp_down = 1'b1;
                end
                n_adjust = fpcc_pkg::ADJ_NONE;
            end
            fpcc_pkg::OP_CHAN1, fpcc_pkg::OP_CHAN2: if (awake && r_power) begin
                if ((r_blink & ch_bit) != 2'b00) begin
                    if (long_press) begin
                        n_blink = r_blink & ~ch_bit;
                        if (n_blink == 2'b00) n_amp = 1'b1;
                    end else if (ch_bit == fpcc_pkg::GROUP_ONE) begin
                        n_pos1 = (ch_pos >= 2'd2) ? 2'd0 : ch_pos + 2'd1;
                    end else begin
                        n_pos2 = (ch_pos >= 2'd2) ? 2'd0 : ch_pos + 2'd1;
                    end
                    n_line = fpcc_pkg::key_one(n_pos1) + fpcc_pkg::key_two(n_pos2);
                end else begin
                    n_blink = r_blink | ch_bit;
                    n_amp   = 1'b0;
                end
            end
            fpcc_pkg::OP_NEXT: if (awake && r_power) begin
                if (long_press) begin
                    n_adjust = (r_adjust ^ fpcc_pkg::ADJ_MINUTES) & fpcc_pkg::ADJ_MINUTES;
                end else begin
                    if (r_adjust[0]) begin
                        n_hour   = (r_hour >= 5'd23) ? 5'd0 : r_hour + 5'd1;
                        n_second = 6'd0;
                    end
                    if (r_adjust[1]) begin
                        n_minute = (r_minute >= 6'd59) ? 6'd0 : r_minute + 6'd1;
                        n_second = 6'd0;
                    end
                    if (r_adjust == fpcc_pkg::ADJ_NONE) begin
                        n_effect = (5'(r_effect) + 5'd1 >= 5'(fpcc_pkg::EFFECT_COUNT))
                                 ? 4'd0 : r_effect + 4'd1;
                    end
                end
            end
            fpcc_pkg::OP_PREV: if (awake && r_power) begin
                if (long_press) begin
                    n_adjust = (r_adjust ^ fpcc_pkg::ADJ_HOURS) & fpcc_pkg::ADJ_HOURS;
                end else begin
                    if (r_adjust[0]) begin
                        n_hour   = (r_hour == 5'd0 || r_hour > 5'd23) ? 5'd23 : r_hour - 5'd1;
                        n_second = 6'd0;
                    end
                    if (r_adjust[1]) begin
                        n_minute = (r_minute == 6'd0 || r_minute > 6'd59)
                                 ? 6'd59 : r_minute - 6'd1;
                        n_second = 6'd0;
                    end
                    if (r_adjust == fpcc_pkg::ADJ_NONE) begin
                        n_effect = (r_effect == 4'd0
                                    || 5'(r_effect) >= 5'(fpcc_pkg::EFFECT_COUNT))
                                 ? fpcc_pkg::EFFECT_LAST : r_effect - 4'd1;
                    end
                end
            end
            fpcc_pkg::OP_LOWVOLT: begin
                n_blink     = 2'b00;
                n_power     = 1'b0;
                n_ramp_up   = 1'b0;
                n_ramp_down = 1'b0;
                n_duty      = 10'd0;
                n_line      = 6'd0;
                n_amp       = 1'b0;
                n_sleep     = 1'b1;
                n_adjust    = fpcc_pkg::ADJ_NONE;
                n_pos1      = 2'd0;
                n_pos2      = 2'd0;
            end
            default: ;
        endcase

        o_result.selector_lines = n_line;
        o_result.effect_code    = n_sleep ? 4'd0 : fpcc_pkg::effect_code(n_effect);
        o_result.effect_index   = n_effect;
        o_result.amp_on         = n_amp;
        o_result.ramp_duty      = n_duty;
        o_result.hours          = n_hour;
        o_result.minutes        = n_minute;
        o_result.seconds        = n_second;
        o_result.adjust_mode    = n_adjust;
        o_result.powered        = n_power;
        o_result.asleep         = n_sleep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power     <= 1'b0;
            r_sleep     <= 1'b0;
            r_line      <= 6'd0;
            r_pos1      <= 2'd0;
            r_pos2      <= 2'd0;
            r_blink     <= 2'b00;
            r_effect    <= 4'd0;
            r_adjust    <= fpcc_pkg::ADJ_NONE;
            r_hour      <= 5'd0;
            r_minute    <= 6'd0;
            r_second    <= 6'd0;
            r_prescale  <= 8'd0;
            r_duty      <= 10'd0;
            r_ramp_up   <= 1'b0;
            r_ramp_down <= 1'b0;
            r_amp       <= 1'b0;
        end else if (i_fire) begin
            r_power     <= n_power;
            r_sleep     <= n_sleep;
            r_line      <= n_line;
            r_pos1      <= n_pos1;
            r_pos2      <= n_pos2;
            r_blink     <= n_blink;
            r_effect    <= n_effect;
            r_adjust    <= n_adjust;
            r_hour      <= n_hour;
            r_minute    <= n_minute;
            r_second    <= n_second;
            r_prescale  <= n_prescale;
            r_duty      <= n_duty;
            r_ramp_up   <= n_ramp_up;
            r_ramp_down <= n_ramp_down;
            r_amp       <= n_amp;
        end
    end
endmodule
`default_nettype wire

### rtl/front_panel_clock_controller.sv
// Top level: front-panel clock controller with input register, event core and result register.
//
//   channel   direction  handshake          payload
//   i_req     in         valid / ready      opcode, hold_ticks
//   o_res     out        valid / ready      panel lines, effect, duty, clock, modes
//   cfg       in         i_cfg_we only      i_cfg_idx, i_cfg_data
//
// One event per cycle sustained while results are taken; a request goes into the input
// register, then a single-pass update carries it into the result register.
// A waiting result freezes the core; the input register holds one more request, then
// ready drops until the result is taken.
// Synchronous active-low reset; the state update loop in the core sets the rate.
`default_nettype none
module front_panel_clock_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    fpcc_in_if.sink          i_req,
    fpcc_out_if.source       o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [11:0] i_cfg_data
);
    fpcc_pkg::t_event  ev;
    fpcc_pkg::t_result core_result;
    fpcc_pkg::t_result r_result;
    logic              r_out_valid;
    logic              advance;
    logic              fire;

    // hold the result until taken; take the next event in the same cycle it leaves
    assign advance = !r_out_valid || o_res.ready;
    assign fire    = ev.valid && advance;

    fpcc_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req.valid),
        .i_opcode     (i_req.opcode),
        .i_hold_ticks (i_req.hold_ticks),
        .o_ready      (i_req.ready),
        .i_advance    (advance),
        .o_event      (ev)
    );

    fpcc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_event    (ev),
        .i_fire     (fire),
        .o_result   (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= ev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= core_result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.selector_lines = r_result.selector_lines;
    assign o_res.effect_code    = r_result.effect_code;
    assign o_res.effect_index   = r_result.effect_index;
    assign o_res.amp_on         = r_result.amp_on;
    assign o_res.ramp_duty      = r_result.ramp_duty;
    assign o_res.hours          = r_result.hours;
    assign o_res.minutes        = r_result.minutes;
    assign o_res.seconds        = r_result.seconds;
    assign o_res.adjust_mode    = r_result.adjust_mode;
    assign o_res.powered        = r_result.powered;
    assign o_res.asleep         = r_result.asleep;
endmodule
`default_nettype wire
